### design/eas_pkg.sv
// Shared widths, constants and register codes for the encoder angle and speed estimator.
`default_nettype none
package eas_pkg;

	localparam int CNT_W     = 12;
	localparam int PP_W      = 6;
	localparam int GAIN_W    = 24;
	localparam int DELTA_W   = 14;
	localparam int SPEED_W   = 32;
	localparam int SUM_W     = 24;
	localparam int WIN_LEN   = 256;
	localparam int WIN_AW    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 24;
	localparam int FRAC_W    = 16;
	localparam int PROD_W    = SUM_W + GAIN_W + 1;
	localparam int HALF_REV  = 2048;
	localparam int REV       = 4096;

	localparam logic [PP_W-1:0]   PP_RESET   = PP_W'(1);
	localparam logic [CNT_W-1:0]  OFS_RESET  = '0;
	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POLE_PAIRS   = 2'd0,
		REG_ANGLE_OFFSET = 2'd1,
		REG_SPEED_GAIN   = 2'd2
	} cfg_reg_t;

endpackage
`default_nettype wire

### design/encoder_angle_speed_estimator.sv
// Top level of the encoder angle and moving-average speed estimator.
// Usage:
//   Input channel (in_valid / in_ready / encoder_count) takes one absolute
//   encoder count per control tick. Output channel (out_valid / out_ready)
//   returns electrical_angle, tick_delta and filtered_speed for every count.
//   cfg_we / cfg_index / cfg_data write pole_pairs (0), angle_offset (1) and
//   speed_gain (2); users must write only while the block is idle (not enforced).
// Timing:
//   A result moves through the s1, s2, s3 and output registers. One item is
//   taken per cycle while the output is not stalled: the delta window lives
//   in a 256-entry RAM read one stage ahead and written back in the next,
//   one slot per item; the window sum feeds the next wrap decision directly.
// Reset:
//   Control and configuration registers return to their reset values at once;
//   window entries not yet written since reset read as zero through a
//   window-filled flag, so no clearing pass is needed. The first count after
//   reset only primes the previous count and reports a zero delta.
// Stall:
//   While out_valid is high and out_ready low the whole pipeline holds and
//   in_ready drops; no result is lost or repeated.
`default_nettype none
module encoder_angle_speed_estimator (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [eas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [eas_pkg::CFG_W-1:0]          cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [eas_pkg::CNT_W-1:0]          encoder_count,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic      [eas_pkg::CNT_W-1:0]          electrical_angle,
	output logic signed [eas_pkg::DELTA_W-1:0]      tick_delta,
	output logic signed [eas_pkg::SPEED_W-1:0]      filtered_speed
);

	logic [eas_pkg::PP_W-1:0]   pole_pairs_q;
	logic [eas_pkg::CNT_W-1:0]  angle_offset_q;
	logic [eas_pkg::GAIN_W-1:0] speed_gain_q;

	logic                        advance;
	logic                        v_s1, v_s2, v_s3;
	logic                        primed_q;
	logic                        filled_q;
	logic [eas_pkg::WIN_AW-1:0]  wr_slot_q;
	logic [eas_pkg::WIN_AW-1:0]  rd_slot;
	logic signed [eas_pkg::SUM_W-1:0] sum_q;
	logic [eas_pkg::CNT_W-1:0]   prev_q;
	logic [eas_pkg::CNT_W-1:0]   count_s1;

	logic signed [eas_pkg::DELTA_W-1:0] rd_data;
	logic signed [eas_pkg::DELTA_W-1:0] old_delta;
	logic signed [eas_pkg::CNT_W:0]     raw_d;
	logic signed [eas_pkg::DELTA_W-1:0] adj_d;
	logic signed [eas_pkg::DELTA_W:0]   neg_d;
	logic signed [eas_pkg::DELTA_W-1:0] delta;
	logic signed [eas_pkg::SUM_W-1:0]   new_sum;
	logic                               win_we;
	logic [eas_pkg::CNT_W+eas_pkg::PP_W-1:0] mech;

	logic [eas_pkg::CNT_W-1:0]          angle_s2, angle_s3;
	logic signed [eas_pkg::DELTA_W-1:0] delta_s2, delta_s3;
	logic signed [eas_pkg::SUM_W-1:0]   sum_s2;
	logic signed [eas_pkg::PROD_W-1:0]  prod_s3;
	logic signed [eas_pkg::PROD_W-eas_pkg::FRAC_W-1:0] shifted;
	logic signed [eas_pkg::SPEED_W-1:0] speed_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pole_pairs_q   <= eas_pkg::PP_RESET;
			angle_offset_q <= eas_pkg::OFS_RESET;
			speed_gain_q   <= eas_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (eas_pkg::cfg_reg_t'(cfg_index))
				eas_pkg::REG_POLE_PAIRS:   pole_pairs_q   <= cfg_data[eas_pkg::PP_W-1:0];
				eas_pkg::REG_ANGLE_OFFSET: angle_offset_q <= cfg_data[eas_pkg::CNT_W-1:0];
				eas_pkg::REG_SPEED_GAIN:   speed_gain_q   <= cfg_data[eas_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;

	assign rd_slot = wr_slot_q + eas_pkg::WIN_AW'(v_s1 && primed_q);
	assign win_we  = advance && v_s1 && primed_q;

	eas_ram #(
		.WIDTH(eas_pkg::DELTA_W),
		.DEPTH(eas_pkg::WIN_LEN)
	) u_window (
		.clk  (clk),
		.we   (win_we),
		.waddr(wr_slot_q),
		.wdata(delta),
		.re   (advance),
		.raddr(rd_slot),
		.rdata(rd_data)
	);

	always_comb begin
		old_delta = filled_q ? rd_data : '0;
		raw_d = $signed({1'b0, count_s1}) - $signed({1'b0, prev_q});
		adj_d = eas_pkg::DELTA_W'(raw_d);
		if (raw_d > (eas_pkg::CNT_W+1)'(eas_pkg::HALF_REV) ||
		    raw_d < -(eas_pkg::CNT_W+1)'(eas_pkg::HALF_REV)) begin
			if (sum_q[eas_pkg::SUM_W-1]) begin
				adj_d = adj_d + eas_pkg::DELTA_W'(eas_pkg::REV);
			end else begin
				adj_d = adj_d - eas_pkg::DELTA_W'(eas_pkg::REV);
			end
		end
		neg_d = -$signed({adj_d[eas_pkg::DELTA_W-1], adj_d});
		if (neg_d[eas_pkg::DELTA_W] != neg_d[eas_pkg::DELTA_W-1]) begin
			delta = neg_d[eas_pkg::DELTA_W] ? {1'b1, {(eas_pkg::DELTA_W-1){1'b0}}}
			                                : {1'b0, {(eas_pkg::DELTA_W-1){1'b1}}};
		end else begin
			delta = neg_d[eas_pkg::DELTA_W-1:0];
		end
		if (!primed_q) begin
			delta = '0;
		end
		new_sum = sum_q - eas_pkg::SUM_W'(old_delta) + eas_pkg::SUM_W'(delta);
		if (!primed_q) begin
			new_sum = sum_q;
		end
		mech = (eas_pkg::CNT_W+eas_pkg::PP_W)'(count_s1) *
		       (eas_pkg::CNT_W+eas_pkg::PP_W)'(pole_pairs_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			out_valid <= 1'b0;
			primed_q  <= 1'b0;
			filled_q  <= 1'b0;
			wr_slot_q <= '0;
			sum_q     <= '0;
			prev_q    <= '0;
		end else if (advance) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			out_valid <= v_s3;
			if (v_s1) begin
				primed_q <= 1'b1;
				prev_q   <= count_s1;
				sum_q    <= new_sum;
				if (primed_q) begin
					wr_slot_q <= wr_slot_q + 1'b1;
					if (wr_slot_q == eas_pkg::WIN_AW'(eas_pkg::WIN_LEN - 1)) begin
						filled_q <= 1'b1;
					end
				end
			end
		end
	end

	always_comb begin
		shifted = prod_s3[eas_pkg::PROD_W-1:eas_pkg::FRAC_W];
		if (shifted[eas_pkg::PROD_W-eas_pkg::FRAC_W-1] != shifted[eas_pkg::SPEED_W-1]) begin
			speed_sat = shifted[eas_pkg::PROD_W-eas_pkg::FRAC_W-1]
			            ? {1'b1, {(eas_pkg::SPEED_W-1){1'b0}}}
			            : {1'b0, {(eas_pkg::SPEED_W-1){1'b1}}};
		end else begin
			speed_sat = shifted[eas_pkg::SPEED_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			count_s1         <= encoder_count;
			angle_s2         <= mech[eas_pkg::CNT_W-1:0] - angle_offset_q;
			delta_s2         <= delta;
			sum_s2           <= new_sum;
			angle_s3         <= angle_s2;
			delta_s3         <= delta_s2;
			prod_s3          <= eas_pkg::PROD_W'(sum_s2) *
			                    eas_pkg::PROD_W'($signed({1'b0, speed_gain_q}));
			electrical_angle <= angle_s3;
			tick_delta       <= delta_s3;
			filtered_speed   <= speed_sat;
		end
	end

endmodule
`default_nettype wire

### design/eas_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module eas_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// Testbench for the encoder angle and speed estimator: random and directed counts checked against a predictor.
`timescale 1ns / 1ps
module testbench;
	import eas_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DELTA_MAX = (1 << (DELTA_W - 1)) - 1;
	localparam int DELTA_MIN = -(1 << (DELTA_W - 1));
	localparam longint SPEED_MAX = (longint'(1) <<< (SPEED_W - 1)) - 1;
	localparam longint SPEED_MIN = -(longint'(1) <<< (SPEED_W - 1));

	typedef struct {
		logic [CNT_W-1:0] angle;
		logic signed [DELTA_W-1:0] delta;
		logic signed [SPEED_W-1:0] speed;
	} tick_result_t;

	class angle_speed_tracker;
		logic [PP_W-1:0] pole_pairs;
		logic [CNT_W-1:0] angle_offset;
		logic [GAIN_W-1:0] speed_gain;
		int delta_window [WIN_LEN];
		int write_slot;
		longint window_sum;
		logic [CNT_W-1:0] previous_count;
		bit primed;
		tick_result_t pending_ticks [$];
		int mismatches;

		function new();
			pole_pairs = PP_RESET;
			angle_offset = OFS_RESET;
			speed_gain = GAIN_RESET;
			foreach (delta_window[k]) delta_window[k] = 0;
			write_slot = 0;
			window_sum = 0;
			previous_count = '0;
			primed = 1'b0;
			mismatches = 0;
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= 50) $display("mismatch: %s", msg);
		endtask

		function void write_register(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_W-1:0] data);
			case (idx)
				REG_POLE_PAIRS: pole_pairs = data[PP_W-1:0];
				REG_ANGLE_OFFSET: angle_offset = data[CNT_W-1:0];
				REG_SPEED_GAIN: speed_gain = data[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		function void note_input(input logic [CNT_W-1:0] count);
			logic [CNT_W+PP_W-1:0] mech_full;
			int d;
			int delta_v;
			longint scaled;
			tick_result_t t;
			mech_full = (CNT_W+PP_W)'(count) * (CNT_W+PP_W)'(pole_pairs);
			t.angle = mech_full[CNT_W-1:0] - angle_offset;
			delta_v = 0;
			if (!primed) begin
				primed = 1'b1;
			end else begin
				d = int'(count) - int'(previous_count);
				if (2 * d > REV || 2 * d < -REV) d = (window_sum < 0) ? d + REV : d - REV;
				delta_v = -d;
				if (delta_v > DELTA_MAX) delta_v = DELTA_MAX;
				if (delta_v < DELTA_MIN) delta_v = DELTA_MIN;
				window_sum = window_sum - delta_window[write_slot] + delta_v;
				delta_window[write_slot] = delta_v;
				write_slot = (write_slot + 1) % WIN_LEN;
			end
			previous_count = count;
			scaled = (window_sum * longint'(speed_gain)) >>> FRAC_W;
			if (scaled > SPEED_MAX) scaled = SPEED_MAX;
			if (scaled < SPEED_MIN) scaled = SPEED_MIN;
			t.delta = delta_v[DELTA_W-1:0];
			t.speed = scaled[SPEED_W-1:0];
			pending_ticks.push_back(t);
		endfunction

		task check_result(input logic [CNT_W-1:0] angle, input logic signed [DELTA_W-1:0] delta,
				input logic signed [SPEED_W-1:0] speed);
			tick_result_t t;
			if (pending_ticks.size() == 0) begin
				report($sformatf("unexpected result angle=%0d delta=%0d speed=%0d",
					angle, delta, speed));
			end else begin
				t = pending_ticks.pop_front();
				if (angle !== t.angle || delta !== t.delta || speed !== t.speed)
					report($sformatf("got angle=%0d delta=%0d speed=%0d, want %0d %0d %0d",
						angle, delta, speed, t.angle, t.delta, t.speed));
			end
		endtask

		task finish_check();
			if (pending_ticks.size() != 0)
				report($sformatf("%0d results never arrived", pending_ticks.size()));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [CNT_W-1:0] encoder_count = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CNT_W-1:0] electrical_angle;
	logic signed [DELTA_W-1:0] tick_delta;
	logic signed [SPEED_W-1:0] filtered_speed;

	angle_speed_tracker tracker = new();
	int cycles = 0;
	bit quiet_source = 1'b0;
	bit quiet_sink = 1'b0;
	int sink_hold = 0;
	int sink_stretch = 0;
	logic [CNT_W-1:0] position = '0;

	encoder_angle_speed_estimator i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.encoder_count(encoder_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.electrical_angle(electrical_angle),
		.tick_delta(tick_delta),
		.filtered_speed(filtered_speed)
	);

	always #5 clk = ~clk;

	function automatic int pick_pause();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
		if (arst_n) begin
			if (in_valid && in_ready) tracker.note_input(encoder_count);
			if (out_valid && out_ready) tracker.check_result(electrical_angle, tick_delta,
				filtered_speed);
		end
	end

	always @(posedge clk) begin
		if (sink_stretch == 0) begin
			quiet_sink = ($urandom_range(0, 3) == 0);
			sink_stretch = $urandom_range(50, 400);
		end else begin
			sink_stretch--;
		end
		if (sink_hold > 0) begin
			sink_hold--;
		end else if (quiet_sink || $urandom_range(0, 1) == 1) begin
			out_ready <= 1'b1;
			sink_hold = $urandom_range(0, 8);
		end else begin
			out_ready <= 1'b0;
			sink_hold = pick_pause();
		end
	end

	task automatic send_count(input logic [CNT_W-1:0] c);
		int gap;
		gap = quiet_source ? 0 : pick_pause();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		encoder_count <= c;
		position = c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending_ticks.size() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		tracker.write_register(idx, data);
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [CFG_W-1:0] pp, input logic [CFG_W-1:0] ofs,
			input logic [CFG_W-1:0] gain);
		write_reg(REG_POLE_PAIRS, pp);
		write_reg(REG_ANGLE_OFFSET, ofs);
		write_reg(REG_SPEED_GAIN, gain);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic run_directed();
		logic [CNT_W-1:0] counts [$];
		counts = '{12'd4095, 12'd0, 12'd4095, 12'd2048, 12'd0, 12'd2049, 12'd2049,
			12'hAAA, 12'h555, 12'd0, 12'd1000, 12'd2000, 12'd3000, 12'd4000,
			12'd904, 12'd3904, 12'd808, 12'd1, 12'd4094};
		foreach (counts[k]) send_count(counts[k]);
	endtask

	task automatic run_stream(input int n_items);
		int left;
		int seg;
		int step;
		int jitter;
		int mag;
		int kind;
		left = n_items;
		while (left > 0) begin
			kind = $urandom_range(0, 9);
			quiet_source = ($urandom_range(0, 4) == 0);
			if (kind < 2) begin
				seg = $urandom_range(1, 20);
				if (seg > left) seg = left;
				repeat (seg) send_count(CNT_W'($urandom_range(0, REV - 1)));
			end else begin
				seg = $urandom_range(8, 300);
				if (seg > left) seg = left;
				case ($urandom_range(0, 3))
					0: mag = 40;
					1: mag = 600;
					2: mag = HALF_REV + 1;
					default: mag = REV - 1;
				endcase
				step = int'($urandom_range(0, 2 * mag)) - mag;
				jitter = (kind == 9) ? 3 : 0;
				repeat (seg) send_count(CNT_W'(position + step
					+ int'($urandom_range(0, 2 * jitter)) - jitter));
			end
			left -= seg;
		end
		quiet_source = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		drain();
		apply_settings(24'hFFFFC0, 24'hABCFFF, 24'h000000);
		write_reg(REG_UNUSED, 24'hFFFFFF);
		cfg_we <= 1'b0;
		@(posedge clk);
		run_stream(275);
		drain();
		apply_settings(24'h00003F, 24'h000000, 24'hFFFFFF);
		run_stream(275);
		drain();
		apply_settings(24'd32, 24'd2048, 24'd1);
		run_stream(275);
		drain();
		apply_settings(24'd1, 24'd0, 24'd65536);
		run_stream(275);
		drain();
		repeat (3) begin
			apply_settings({18'($urandom), 6'($urandom_range(1, 32))}, CFG_W'($urandom),
				CFG_W'($urandom));
			write_reg(REG_UNUSED, CFG_W'($urandom));
			cfg_we <= 1'b0;
			@(posedge clk);
			run_stream(275);
			drain();
		end
		repeat (8) @(posedge clk);
		tracker.finish_check();
		if (tracker.mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
